[src/bcm_pkg.sv]
package bcm_pkg;

   // field widths
   localparam int unsigned FIELD_W  = 12;
   localparam int unsigned VALUE_W  = 30;
   localparam int unsigned STATUS_W = 2;

   // modulus and default table depth
   localparam logic [VALUE_W-1:0] PRIME = 30'd1000000007;
   localparam int unsigned DEFAULT_DEPTH = 4096;

   // item modes
   localparam logic MODE_BUILD = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ORDER = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BUILT = 2'd3;

   // operand bits handled by the serial units
   localparam int unsigned SERIAL_STEPS = VALUE_W;
   localparam int unsigned STEP_CNT_W   = $clog2(SERIAL_STEPS);

   typedef logic [VALUE_W-1:0] value_type;

endpackage

[src/bcm_if.sv]
// request channel
interface bcm_req_if;
   import bcm_pkg::*;
   logic                valid;
   logic                ready;
   logic                mode;
   logic [FIELD_W-1:0]  top;
   logic [FIELD_W-1:0]  bottom;

   modport source (output valid, output mode, output top, output bottom, input ready);
   modport sink   (input valid, input mode, input top, input bottom, output ready);
endinterface

// response channel
interface bcm_rsp_if;
   import bcm_pkg::*;
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  value;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

[src/bcm_ram.sv]
module bcm_ram #(
   parameter int unsigned WIDTH = 30,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

[src/bcm_mulmod.sv]
module bcm_mulmod (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [bcm_pkg::VALUE_W-1:0] a,
   input  logic [bcm_pkg::VALUE_W-1:0] b,
   output logic                     done,
   output logic [bcm_pkg::VALUE_W-1:0] result
);
   import bcm_pkg::*;

   localparam logic [VALUE_W+1:0] P1 = {2'b00, PRIME};
   localparam logic [VALUE_W+1:0] P2 = {1'b0, PRIME, 1'b0};

   logic [VALUE_W-1:0]    acc_ff, acc_in;
   logic [VALUE_W-1:0]    a_ff;
   logic [VALUE_W-1:0]    b_ff;
   logic [STEP_CNT_W-1:0] cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [VALUE_W+1:0]    sum;

   // double and add, operands below the prime so the sum stays under 3p
   always_comb begin
      sum = {1'b0, acc_ff, 1'b0} + (b_ff[VALUE_W-1] ? {2'b00, a_ff} : '0);
      if (sum >= P2) begin
         acc_in = VALUE_W'(sum - P2);
      end else if (sum >= P1) begin
         acc_in = VALUE_W'(sum - P1);
      end else begin
         acc_in = VALUE_W'(sum);
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(SERIAL_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         a_ff   <= a;
         b_ff   <= b;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         b_ff   <= {b_ff[VALUE_W-2:0], 1'b0};
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;
endmodule

[src/bcm_divp.sv]
module bcm_divp #(
   parameter int unsigned DIV_W = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DIV_W-1:0]            divisor,
   output logic                        done,
   output logic [bcm_pkg::VALUE_W-1:0] quotient,
   output logic [DIV_W-1:0]            remainder
);
   import bcm_pkg::*;

   logic [VALUE_W-1:0]    pbits_ff;
   logic [VALUE_W-1:0]    quo_ff;
   logic [DIV_W-1:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]      den_ff;
   logic                  qbit;
   logic [STEP_CNT_W-1:0] cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_W:0]        trial;

   // one restoring step of the prime over the divisor
   always_comb begin
      trial = {rem_ff, pbits_ff[VALUE_W-1]};
      qbit  = (trial >= {1'b0, den_ff});
      if (qbit) begin
         rem_in = DIV_W'(trial - {1'b0, den_ff});
      end else begin
         rem_in = DIV_W'(trial);
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(SERIAL_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         pbits_ff <= PRIME;
         quo_ff   <= '0;
         rem_ff   <= '0;
         den_ff   <= divisor;
      end else if (busy_ff) begin
         pbits_ff <= {pbits_ff[VALUE_W-2:0], 1'b0};
         quo_ff   <= {quo_ff[VALUE_W-2:0], qbit};
         rem_ff   <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

[src/modular_binomial_coefficient.sv]
// Binomial coefficients modulo 1000000007 from three tables held in single-port
// RAMs (factorials, inverses, inverse factorials). A build item (mode 0) fills
// indices 0 up to csr_wdata's limit (clamped to 1..TABLE_DEPTH-1) and answers
// with status 3. Entries 0 and 1 are written in S_INIT0 and S_INIT1. Each
// further index takes a serial division of the prime, one table read and three
// bit-serial modular multiplies. A query (mode 1) returns
// fac[top]*invfac[bottom]*invfac[top-bottom] after three table reads and two
// serial multiplies. Bottom above top answers status 1. Top beyond the built
// limit (or no build yet) answers status 2. Both flagged cases go straight to
// the result state. One item is in work at a time; the result register holds
// while the next item is taken.
module modular_binomial_coefficient #(
   parameter int unsigned TABLE_DEPTH = bcm_pkg::DEFAULT_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   bcm_req_if.sink                     req_chan,
   bcm_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic [bcm_pkg::FIELD_W-1:0] csr_wdata
);
   import bcm_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned IW = AW + 1;
   localparam int unsigned CW = (AW > FIELD_W) ? AW : FIELD_W;
   localparam logic [CW-1:0] MAX_IDX = CW'(TABLE_DEPTH - 1);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_INIT0 = 5'd1;
   localparam logic [4:0] S_INIT1 = 5'd2;
   localparam logic [4:0] S_DGO   = 5'd3;
   localparam logic [4:0] S_DWAIT = 5'd4;
   localparam logic [4:0] S_RDINV = 5'd5;
   localparam logic [4:0] S_MT    = 5'd6;
   localparam logic [4:0] S_WT    = 5'd7;
   localparam logic [4:0] S_MF    = 5'd8;
   localparam logic [4:0] S_WF    = 5'd9;
   localparam logic [4:0] S_MI    = 5'd10;
   localparam logic [4:0] S_WI    = 5'd11;
   localparam logic [4:0] S_Q0    = 5'd12;
   localparam logic [4:0] S_Q1    = 5'd13;
   localparam logic [4:0] S_Q2    = 5'd14;
   localparam logic [4:0] S_QW1   = 5'd15;
   localparam logic [4:0] S_QM2   = 5'd16;
   localparam logic [4:0] S_QW2   = 5'd17;
   localparam logic [4:0] S_DONE  = 5'd18;

   logic [4:0]          state_ff, state_in;
   logic [FIELD_W-1:0]  limit_ff;
   logic [AW-1:0]       built_ff;
   logic                tvalid_ff;
   logic [AW-1:0]       last_ff;
   logic [IW-1:0]       idx_ff;
   logic [FIELD_W-1:0]  top_ff, bottom_ff;
   value_type           facp_ff, invfp_ff, inv_ff, opa_ff, opb_ff, opc_ff;
   value_type           val_ff;
   logic [STATUS_W-1:0] stat_ff;
   logic                rsp_valid_ff;
   value_type           rsp_value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic                req_fire, load_rsp, last_idx;
   logic [CW-1:0]       lim_c, top_c, bottom_c, built_c;
   logic [AW-1:0]       last_c;
   logic [AW-1:0]       top_a, bottom_a, diff_a, idx_a;
   value_type           inv_new;

   logic                fac_we, inv_we, ifc_we;
   logic [AW-1:0]       fac_addr, inv_addr, ifc_addr;
   value_type           fac_wd, inv_wd, ifc_wd;
   value_type           fac_rd, inv_rd, ifc_rd;

   logic                mm_start, mm_done;
   value_type           mm_a, mm_b, mm_res;
   logic                dv_start, dv_done;
   value_type           dv_quo;
   logic [IW-1:0]       dv_rem;

   // table memories
   bcm_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_fac_ram (
      .clock(clock), .we(fac_we), .addr(fac_addr), .wdata(fac_wd), .rdata(fac_rd));
   bcm_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_inv_ram (
      .clock(clock), .we(inv_we), .addr(inv_addr), .wdata(inv_wd), .rdata(inv_rd));
   bcm_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_ifc_ram (
      .clock(clock), .we(ifc_we), .addr(ifc_addr), .wdata(ifc_wd), .rdata(ifc_rd));

   // shared serial units
   bcm_mulmod u_mulmod (
      .clock(clock), .reset(reset), .start(mm_start), .a(mm_a), .b(mm_b),
      .done(mm_done), .result(mm_res));
   bcm_divp #(.DIV_W(IW)) u_divp (
      .clock(clock), .reset(reset), .start(dv_start), .divisor(idx_ff),
      .done(dv_done), .quotient(dv_quo), .remainder(dv_rem));

   // handshake
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign load_rsp       = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // index arithmetic
   assign lim_c    = CW'(limit_ff);
   assign top_c    = CW'(req_chan.top);
   assign bottom_c = CW'(req_chan.bottom);
   assign built_c  = CW'(built_ff);
   assign top_a    = AW'(top_ff);
   assign bottom_a = AW'(bottom_ff);
   assign diff_a   = AW'(top_ff - bottom_ff);
   assign idx_a    = idx_ff[AW-1:0];
   assign last_idx = (idx_a == last_ff);
   assign inv_new  = (mm_res == '0) ? '0 : PRIME - mm_res;

   always_comb begin
      if (lim_c < CW'(1)) begin
         last_c = AW'(1);
      end else if (lim_c > MAX_IDX) begin
         last_c = AW'(MAX_IDX);
      end else begin
         last_c = AW'(lim_c);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.mode == MODE_BUILD) begin
                  state_in = S_INIT0;
               end else if (bottom_c > top_c) begin
                  state_in = S_DONE;
               end else if (!tvalid_ff || top_c > built_c) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_Q0;
               end
            end
         end
         S_INIT0: state_in = S_INIT1;
         S_INIT1: state_in = (last_ff == AW'(1)) ? S_DONE : S_DGO;
         S_DGO:   state_in = S_DWAIT;
         S_DWAIT: state_in = dv_done ? S_RDINV : S_DWAIT;
         S_RDINV: state_in = S_MT;
         S_MT:    state_in = S_WT;
         S_WT:    state_in = mm_done ? S_MF : S_WT;
         S_MF:    state_in = S_WF;
         S_WF:    state_in = mm_done ? S_MI : S_WF;
         S_MI:    state_in = S_WI;
         S_WI: begin
            if (mm_done) begin
               state_in = last_idx ? S_DONE : S_DGO;
            end
         end
         S_Q0:    state_in = S_Q1;
         S_Q1:    state_in = S_Q2;
         S_Q2:    state_in = S_QW1;
         S_QW1:   state_in = mm_done ? S_QM2 : S_QW1;
         S_QM2:   state_in = S_QW2;
         S_QW2:   state_in = mm_done ? S_DONE : S_QW2;
         S_DONE:  state_in = load_rsp ? S_IDLE : S_DONE;
         default: state_in = S_IDLE;
      endcase
   end

   // unit starts and operands
   assign dv_start = (state_ff == S_DGO);
   assign mm_start = (state_ff == S_MT) || (state_ff == S_MF) || (state_ff == S_MI)
                     || (state_ff == S_Q2) || (state_ff == S_QM2);
   always_comb begin
      case (state_ff)
         S_MT:    begin mm_a = inv_rd;  mm_b = dv_quo;          end
         S_MF:    begin mm_a = facp_ff; mm_b = VALUE_W'(idx_ff); end
         S_MI:    begin mm_a = invfp_ff; mm_b = inv_ff;         end
         S_Q2:    begin mm_a = opa_ff;  mm_b = opb_ff;          end
         default: begin mm_a = opa_ff;  mm_b = opc_ff;          end
      endcase
   end

   // memory ports
   always_comb begin
      fac_we = 1'b0; inv_we = 1'b0; ifc_we = 1'b0;
      fac_addr = top_a; inv_addr = idx_a; ifc_addr = bottom_a;
      fac_wd = VALUE_W'(1); inv_wd = VALUE_W'(1); ifc_wd = VALUE_W'(1);
      case (state_ff)
         S_INIT0, S_INIT1: begin
            fac_we = 1'b1; inv_we = 1'b1; ifc_we = 1'b1;
            fac_addr = (state_ff == S_INIT0) ? AW'(0) : AW'(1);
            inv_addr = fac_addr;
            ifc_addr = fac_addr;
         end
         S_RDINV: inv_addr = dv_rem[AW-1:0];
         S_WT: begin
            inv_we = mm_done;
            inv_wd = inv_new;
         end
         S_WF: begin
            fac_we   = mm_done;
            fac_addr = idx_a;
            fac_wd   = mm_res;
         end
         S_WI: begin
            ifc_we   = mm_done;
            ifc_addr = idx_a;
            ifc_wd   = mm_res;
         end
         S_Q1:    ifc_addr = diff_a;
         default: ifc_addr = bottom_a;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= FIELD_W'(1);
         built_ff     <= '0;
         tvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if ((state_ff == S_INIT1 && last_ff == AW'(1))
             || (state_ff == S_WI && mm_done && last_idx)) begin
            built_ff  <= last_ff;
            tvalid_ff <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         top_ff    <= req_chan.top;
         bottom_ff <= req_chan.bottom;
         last_ff   <= last_c;
         idx_ff    <= IW'(2);
         val_ff    <= '0;
         facp_ff   <= VALUE_W'(1);
         invfp_ff  <= VALUE_W'(1);
         if (req_chan.mode == MODE_BUILD) begin
            stat_ff <= ST_BUILT;
         end else if (bottom_c > top_c) begin
            stat_ff <= ST_ORDER;
         end else if (!tvalid_ff || top_c > built_c) begin
            stat_ff <= ST_RANGE;
         end else begin
            stat_ff <= ST_OK;
         end
      end
      if (state_ff == S_WT && mm_done) begin
         inv_ff <= inv_new;
      end
      if (state_ff == S_WF && mm_done) begin
         facp_ff <= mm_res;
      end
      if (state_ff == S_WI && mm_done) begin
         invfp_ff <= mm_res;
         idx_ff   <= idx_ff + 1'b1;
      end
      if (state_ff == S_Q1) begin
         opa_ff <= fac_rd;
         opb_ff <= ifc_rd;
      end
      if (state_ff == S_Q2) begin
         opc_ff <= ifc_rd;
      end
      if (state_ff == S_QW1 && mm_done) begin
         opa_ff <= mm_res;
      end
      if (state_ff == S_QW2 && mm_done) begin
         val_ff <= mm_res;
      end
      if (load_rsp) begin
         rsp_value_ff  <= val_ff;
         rsp_status_ff <= stat_ff;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.value  = rsp_value_ff;
   assign rsp_chan.status = rsp_status_ff;
endmodule

[src/bcm_checker.sv]
module bcm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bcm_pkg::VALUE_W-1:0]  rsp_value,
   input logic [bcm_pkg::STATUS_W-1:0] rsp_status
);
   import bcm_pkg::*;

   // a pending result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before taken");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while busy");

   // flagged and build results carry zero
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_value == '0)
      else $error("nonzero value with flag");

   // results reduced below the prime
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_value < PRIME)
      else $error("value not reduced");
endmodule

bind modular_binomial_coefficient bcm_checker u_bcm_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_value(rsp_chan.value),
   .rsp_status(rsp_chan.status)
);

[tb/sv/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bcm_pkg::*;

   localparam int unsigned DEPTH = DEFAULT_DEPTH;
   localparam longint unsigned P = 64'd1000000007;

   typedef struct packed {
      logic               mode;
      logic [FIELD_W-1:0] top;
      logic [FIELD_W-1:0] bottom;
   } bcm_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } bcm_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [FIELD_W-1:0] csr_wdata;

   bcm_req_if req_chan ();
   bcm_rsp_if rsp_chan ();

   modular_binomial_coefficient #(.TABLE_DEPTH(DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [VALUE_W-1:0] fact_tab [DEPTH];
   logic [VALUE_W-1:0] inv_tab [DEPTH];
   logic [VALUE_W-1:0] inv_fact_tab [DEPTH];
   logic [FIELD_W-1:0] cfg_table_limit;
   logic [FIELD_W-1:0] pred_built_limit;
   bit                 pred_tables_built;

   bcm_item_type   pending_items[$];
   bcm_result_type expected_results[$];
   int unsigned error_count;
   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   bit          sender_hold;

   function automatic logic [VALUE_W-1:0] mod_mult(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
      longint unsigned prod;
      prod = (64'(a) * 64'(b)) % P;
      return prod[VALUE_W-1:0];
   endfunction

   // fill the tables up to the configured limit
   function automatic void build_binomial_tables();
      int unsigned last;
      int unsigned r;
      logic [VALUE_W-1:0] q;
      logic [VALUE_W-1:0] t;
      last = cfg_table_limit;
      if (last < 1) last = 1;
      if (last > DEPTH - 1) last = DEPTH - 1;
      fact_tab[0] = 1; fact_tab[1] = 1;
      inv_tab[0] = 1; inv_tab[1] = 1;
      inv_fact_tab[0] = 1; inv_fact_tab[1] = 1;
      for (int unsigned i = 2; i <= last; i++) begin
         r = int'(P % i);
         q = VALUE_W'(P / i);
         t = mod_mult(inv_tab[r], q);
         fact_tab[i] = mod_mult(fact_tab[i-1], VALUE_W'(i));
         inv_tab[i] = (t == 0) ? '0 : VALUE_W'(P - 64'(t));
         inv_fact_tab[i] = mod_mult(inv_fact_tab[i-1], inv_tab[i]);
      end
      pred_built_limit = FIELD_W'(last);
      pred_tables_built = 1'b1;
   endfunction

   // expected result of one accepted item
   function automatic bcm_result_type predict_binomial(bcm_item_type it);
      bcm_result_type res;
      res.value = '0;
      if (it.mode == MODE_BUILD) begin
         build_binomial_tables();
         res.status = ST_BUILT;
      end else if (it.bottom > it.top) begin
         res.status = ST_ORDER;
      end else if (!pred_tables_built || it.top > pred_built_limit) begin
         res.status = ST_RANGE;
      end else begin
         res.value = mod_mult(mod_mult(fact_tab[it.top], inv_fact_tab[it.bottom]),
                              inv_fact_tab[it.top - it.bottom]);
         res.status = ST_OK;
      end
      return res;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      bcm_item_type   cur;
      bcm_item_type   nxt;
      bcm_result_type exp_new;
      bit             send;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            cur.mode = req_chan.mode;
            cur.top = req_chan.top;
            cur.bottom = req_chan.bottom;
            exp_new = predict_binomial(cur);
            expected_results.insert(expected_results.size(), exp_new);
         end
         if (!req_chan.valid || req_chan.ready) begin
            send = pending_items.size() > 0 && !sender_hold &&
                   $urandom_range(99, 0) >= sender_idle_pct;
            if (send) begin
               nxt = pending_items.pop_front();
               req_chan.mode <= nxt.mode;
               req_chan.top <= nxt.top;
               req_chan.bottom <= nxt.bottom;
            end
            req_chan.valid <= send;
         end
      end
   end

   // result monitor and ready stalls
   always @(posedge clock) begin
      bcm_result_type exp_res;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result value=%0d status=%0d", rsp_chan.value, rsp_chan.status);
               error_count++;
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_chan.value !== exp_res.value) begin
                  $error("value: expected %0d, got %0d", exp_res.value, rsp_chan.value);
                  error_count++;
               end
               if (rsp_chan.status !== exp_res.status) begin
                  $error("status: expected %0d, got %0d", exp_res.status, rsp_chan.status);
                  error_count++;
               end
            end
         end
         rsp_chan.ready <= $urandom_range(99, 0) >= receiver_stall_pct;
      end
   end

   task automatic add_item(logic mode, int unsigned top, int unsigned bottom);
      bcm_item_type it;
      it.mode = mode;
      it.top = FIELD_W'(top);
      it.bottom = FIELD_W'(bottom);
      pending_items.insert(pending_items.size(), it);
   endtask

   // sampled away from the active edge so driver updates have settled
   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() > 0 || req_chan.valid || expected_results.size() > 0)
         @(negedge clock);
   endtask

   task automatic write_limit(int unsigned lim);
      wait_drained();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= FIELD_W'(lim);
      cfg_table_limit = FIELD_W'(lim);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // random phase: a build at a small limit, then mostly valid queries
   task automatic random_phase(int unsigned n_items);
      int unsigned lim;
      int unsigned top;
      int unsigned bottom;
      int unsigned pick;
      lim = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 2) : $urandom_range(60, 0);
      write_limit(lim);
      add_item(MODE_BUILD, $urandom_range(4095, 0), $urandom_range(4095, 0));
      for (int unsigned i = 0; i < n_items; i++) begin
         pick = $urandom_range(99, 0);
         if (pick < 3) begin
            add_item(MODE_BUILD, $urandom_range(4095, 0), $urandom_range(4095, 0));
         end else if (pick < 80) begin
            top = $urandom_range((lim < 1 ? 1 : lim), 0);
            bottom = $urandom_range(top, 0);
            add_item(MODE_QUERY, top, bottom);
         end else if (pick < 90) begin
            top = $urandom_range(lim + 6, 0);
            add_item(MODE_QUERY, top, $urandom_range(4095, 0));
         end else begin
            add_item(MODE_QUERY, $urandom_range(4095, 0), $urandom_range(4095, 0));
         end
      end
      // hold the sender until everything is back
      while (pending_items.size() > n_items / 2) @(negedge clock);
      sender_hold = 1'b1;
      @(negedge clock);
      while (req_chan.valid || expected_results.size() > 0) @(negedge clock);
      sender_hold = 1'b0;
   endtask

   // stimulus
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_QUERY;
      req_chan.top = '0;
      req_chan.bottom = '0;
      rsp_chan.ready = 1'b0;
      cfg_table_limit = 1;
      pred_built_limit = '0;
      pred_tables_built = 1'b0;
      error_count = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      sender_hold = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // before any build, then the default limit of one
      add_item(MODE_QUERY, 0, 0);
      add_item(MODE_QUERY, 5, 3);
      add_item(MODE_QUERY, 3, 5);
      add_item(MODE_QUERY, 0, 4095);
      add_item(MODE_BUILD, 0, 0);
      add_item(MODE_QUERY, 1, 0);
      add_item(MODE_QUERY, 1, 1);
      add_item(MODE_QUERY, 0, 0);
      add_item(MODE_QUERY, 2, 1);
      add_item(MODE_QUERY, 4095, 4095);
      // limit zero still builds entries 0 and 1
      write_limit(0);
      add_item(MODE_BUILD, 4095, 4095);
      add_item(MODE_QUERY, 1, 1);
      add_item(MODE_QUERY, 2, 0);
      // full table
      write_limit(4095);
      add_item(MODE_BUILD, 0, 0);
      add_item(MODE_QUERY, 4095, 0);
      add_item(MODE_QUERY, 4095, 4095);
      add_item(MODE_QUERY, 4095, 2047);
      add_item(MODE_QUERY, 4095, 4094);
      add_item(MODE_QUERY, 2730, 1365);
      add_item(MODE_QUERY, 4094, 4095);
      // rebuild with a smaller limit
      write_limit(3);
      add_item(MODE_BUILD, 0, 0);
      add_item(MODE_QUERY, 4095, 0);
      add_item(MODE_QUERY, 3, 2);

      random_phase(230);
      sender_idle_pct = 70;
      random_phase(230);
      sender_idle_pct = 0;
      receiver_stall_pct = 70;
      random_phase(230);
      sender_idle_pct = 18;
      receiver_stall_pct = 18;
      random_phase(230);

      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #100ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
